@@ rtl/lca_pkg.sv @@
// ----------------------------------------------------------------------------
// lca_pkg
// shared types, constants and codes of the light change alert block
// ----------------------------------------------------------------------------
`default_nettype none

package lca_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int LUX_BITS_DEF  = 16;
  localparam int PCT_W         = 23;
  localparam int STATUS_W      = 3;
  localparam int CFG_IDX_W     = 3;
  localparam int DELTA_W       = 16;
  localparam int PCT_SCALE     = 100;

  localparam int INIT_WAIT_RST = 30000;
  localparam int INTERVAL_RST  = 1000;
  localparam int DELTA_RST     = 20;
  localparam int RETRIG_RST    = 60000;

  typedef enum logic [STATUS_W-1:0] {
    ST_IGNORED    = 3'd0,
    ST_FIRST      = 3'd1,
    ST_BOTH_ZERO  = 3'd2,
    ST_SMALL      = 3'd3,
    ST_ALERT      = 3'd4,
    ST_SUPPRESSED = 3'd5
  } lca_status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE    = 3'd0,
    REG_BOOT_TIME = 3'd1,
    REG_INIT_WAIT = 3'd2,
    REG_INTERVAL  = 3'd3,
    REG_DELTA     = 3'd4,
    REG_RETRIG    = 3'd5
  } lca_reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_FINISH
  } lca_state_t;

  typedef enum logic [1:0] {
    K_IGNORE,
    K_FIRST,
    K_BOTH_ZERO,
    K_DIVIDE
  } lca_kind_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic step;
    logic finish;
  } lca_cmd_t;

  typedef struct packed {
    logic need_div;
    logic out_free;
  } lca_sts_t;

endpackage

`default_nettype wire

@@ rtl/lca_if.sv @@
// ----------------------------------------------------------------------------
// lca_in_if / lca_out_if
// valid/ready request channels of the light change alert block
// ----------------------------------------------------------------------------
`default_nettype none

interface lca_in_if #(
  parameter int TIME_BITS = lca_pkg::TIME_BITS_DEF,
  parameter int LUX_BITS  = lca_pkg::LUX_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] now_ms;
  logic [LUX_BITS-1:0]  lux;

  modport source (output valid, output now_ms, output lux, input ready);
  modport sink   (input valid, input now_ms, input lux, output ready);
endinterface

interface lca_out_if #(
  parameter int LUX_BITS = lca_pkg::LUX_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [lca_pkg::STATUS_W-1:0]  status;
  logic [LUX_BITS-1:0]           old_lux;
  logic [LUX_BITS-1:0]           new_lux;
  logic [lca_pkg::PCT_W-1:0]     percent_change;

  modport source (output valid, output status, output old_lux, output new_lux,
                  output percent_change, input ready);
  modport sink   (input valid, input status, input old_lux, input new_lux,
                  input percent_change, output ready);
endinterface

`default_nettype wire

@@ rtl/lca_ctrl.sv @@
// ----------------------------------------------------------------------------
// lca_ctrl
// sequencer: accept, evaluate, divide one bit per cycle when a division is needed, deliver
// ----------------------------------------------------------------------------
`default_nettype none

module lca_ctrl import lca_pkg::*; #(
  parameter int LUX_BITS = LUX_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire lca_sts_t sts,
  output lca_cmd_t      cmd
);

  localparam int NW    = LUX_BITS + 7;
  localparam int CNT_W = $clog2(NW);

  lca_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (sts.need_div) begin
          cnt_nxt   = CNT_W'(NW - 1);
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_FINISH;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV && cnt_r == '0 |=> state_r == S_FINISH)
    else $error("divider did not hand over to finish");

endmodule

`default_nettype wire

@@ rtl/lca_dp.sv @@
// ----------------------------------------------------------------------------
// lca_dp
// registers, sample gating, restoring divider and result register
// ----------------------------------------------------------------------------
`default_nettype none

module lca_dp import lca_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF,
  parameter int LUX_BITS  = LUX_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [TIME_BITS-1:0] cfg_wdata,
  input  wire logic [TIME_BITS-1:0] in_now_ms,
  input  wire logic [LUX_BITS-1:0]  in_lux,
  input  wire lca_cmd_t             cmd,
  output lca_sts_t                  sts,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [STATUS_W-1:0]       out_status,
  output logic [LUX_BITS-1:0]       out_old_lux,
  output logic [LUX_BITS-1:0]       out_new_lux,
  output logic [PCT_W-1:0]          out_pct
);

  localparam int NW = LUX_BITS + 7;
  localparam int CW = (NW > DELTA_W) ? NW : DELTA_W;

  // configuration
  logic                 enable_r;
  logic [TIME_BITS-1:0] boot_r, init_wait_r, interval_r, retrig_r;
  logic [DELTA_W-1:0]   delta_r;

  // state
  logic [LUX_BITS-1:0]  stored_r;
  logic [TIME_BITS-1:0] last_sample_r, last_alert_r;

  // request and work registers
  logic [TIME_BITS-1:0] now_r;
  logic [LUX_BITS-1:0]  lux_r;
  lca_kind_t            kind_r;
  logic [NW-1:0]        quo_r;
  logic [LUX_BITS-1:0]  rem_r;

  // result register
  logic                 out_valid_r;
  lca_status_t          out_status_r, out_status_nxt;
  logic [LUX_BITS-1:0]  out_old_r, out_old_nxt, out_new_r, out_new_nxt;
  logic [PCT_W-1:0]     out_pct_r, out_pct_nxt;

  logic [TIME_BITS-1:0] el_boot, el_sample, el_alert;
  logic                 take, old_zero, big, retrig_ok;
  logic [LUX_BITS-1:0]  diff;
  logic [NW-1:0]        diff_w, dividend;
  logic [LUX_BITS:0]    rem_sh, rem_sub;
  logic                 ge;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      boot_r      <= '0;
      init_wait_r <= TIME_BITS'(INIT_WAIT_RST);
      interval_r  <= TIME_BITS'(INTERVAL_RST);
      delta_r     <= DELTA_W'(DELTA_RST);
      retrig_r    <= TIME_BITS'(RETRIG_RST);
    end else if (cfg_we) begin
      unique case (lca_reg_idx_t'(cfg_index))
        REG_ENABLE:    enable_r    <= cfg_wdata[0];
        REG_BOOT_TIME: boot_r      <= cfg_wdata;
        REG_INIT_WAIT: init_wait_r <= cfg_wdata;
        REG_INTERVAL:  interval_r  <= cfg_wdata;
        REG_DELTA:     delta_r     <= cfg_wdata[DELTA_W-1:0];
        REG_RETRIG:    retrig_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sample gating and divider set-up
  always_comb begin
    el_boot   = now_r - boot_r;
    el_sample = now_r - last_sample_r;
    el_alert  = now_r - last_alert_r;
    take      = enable_r && (el_boot >= init_wait_r) && (el_sample >= interval_r);
    old_zero  = (stored_r == '0);
    diff      = (lux_r >= stored_r) ? (lux_r - stored_r) : (stored_r - lux_r);
    diff_w    = NW'(diff);
    dividend  = (diff_w << 6) + (diff_w << 5) + (diff_w << 2);
    rem_sh    = {rem_r, quo_r[NW-1]};
    rem_sub   = rem_sh - {1'b0, stored_r};
    ge        = (rem_sh >= {1'b0, stored_r});
    big       = (CW'(quo_r) >= CW'(delta_r));
    retrig_ok = (el_alert >= retrig_r);
  end

  assign sts.need_div = take && !old_zero;
  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r <= in_now_ms;
      lux_r <= in_lux;
    end
    if (cmd.eval) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (cmd.step) begin
      quo_r <= {quo_r[NW-2:0], ge};
      rem_r <= ge ? rem_sub[LUX_BITS-1:0] : rem_sh[LUX_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= K_IGNORE;
    end else if (cmd.eval) begin
      if (!take) begin
        kind_r <= K_IGNORE;
      end else if (!old_zero) begin
        kind_r <= K_DIVIDE;
      end else if (lux_r == '0) begin
        kind_r <= K_BOTH_ZERO;
      end else begin
        kind_r <= K_FIRST;
      end
    end
  end

  // result of the finishing cycle
  always_comb begin
    out_status_nxt = ST_IGNORED;
    out_old_nxt    = '0;
    out_new_nxt    = '0;
    out_pct_nxt    = '0;
    unique case (kind_r)
      K_IGNORE: ;
      K_FIRST: begin
        out_status_nxt = ST_FIRST;
        out_new_nxt    = lux_r;
      end
      K_BOTH_ZERO: out_status_nxt = ST_BOTH_ZERO;
      K_DIVIDE: begin
        out_old_nxt = stored_r;
        out_new_nxt = lux_r;
        out_pct_nxt = PCT_W'(quo_r);
        if (!big) begin
          out_status_nxt = ST_SMALL;
        end else if (retrig_ok) begin
          out_status_nxt = ST_ALERT;
        end else begin
          out_status_nxt = ST_SUPPRESSED;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stored_r      <= '0;
      last_sample_r <= '0;
      last_alert_r  <= '0;
    end else if (cmd.finish && kind_r != K_IGNORE) begin
      last_sample_r <= now_r;
      if (kind_r != K_BOTH_ZERO) begin
        stored_r <= lux_r;
      end
      if (out_status_nxt == ST_ALERT) begin
        last_alert_r <= now_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status_r <= out_status_nxt;
      out_old_r    <= out_old_nxt;
      out_new_r    <= out_new_nxt;
      out_pct_r    <= out_pct_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_old_lux = out_old_r;
  assign out_new_lux = out_new_r;
  assign out_pct     = out_pct_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before delivery");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (rem_r < stored_r))
    else $error("divider remainder not below divisor");

  a_ignored_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish && kind_r == K_IGNORE |=>
      out_valid_r && out_status_r == ST_IGNORED && out_pct_r == '0 && out_new_r == '0)
    else $error("ignored request gave a nonzero result");

endmodule

`default_nettype wire

@@ rtl/light_change_alert.sv @@
// ----------------------------------------------------------------------------
// light_change_alert
// light level change detector with startup wait, sample interval and
// alert retrigger hold-off
// ----------------------------------------------------------------------------
//  channel   dir  handshake         payload
//  in_chan   in   valid/ready       now_ms, lux
//  out_chan  out  valid/ready       status, old_lux, new_lux, percent_change
//  cfg_*     in   write enable      cfg_index, cfg_wdata
//
//  a request steps from acceptance through evaluate, the divider and finish
//  to the next accept; the restoring divider makes one quotient bit per cycle;
//  a request with no division (ignored, first or both zero) skips the divider
//  the result register lets the next request in while a result waits
//  a stalled result holds the sequencer only in its finishing cycle
//  synchronous reset, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module light_change_alert import lca_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF,
  parameter int LUX_BITS  = LUX_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  lca_in_if.sink                    in_chan,
  lca_out_if.source                 out_chan,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [TIME_BITS-1:0] cfg_wdata
);

  lca_cmd_t cmd;
  lca_sts_t sts;

  lca_ctrl #(
    .LUX_BITS (LUX_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lca_dp #(
    .TIME_BITS (TIME_BITS),
    .LUX_BITS  (LUX_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_now_ms   (in_chan.now_ms),
    .in_lux      (in_chan.lux),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_chan.valid),
    .out_ready   (out_chan.ready),
    .out_status  (out_chan.status),
    .out_old_lux (out_chan.old_lux),
    .out_new_lux (out_chan.new_lux),
    .out_pct     (out_chan.percent_change)
  );

endmodule

`default_nettype wire
